@@ design/tpaf_pkg.sv @@
// Shared types and constants of the triac phase-angle firing controller.
`timescale 1ns / 1ps
`default_nettype none

package tpaf_pkg;

  localparam int unsigned NUM_CHANNELS = 3;
  localparam logic [6:0] FULL_POWER = 7'd100;

  localparam logic [6:0]  MAX_POWER_RST      = 7'd100;
  localparam logic [15:0] HALF_PERIOD_RST    = 16'd10000;
  localparam logic [15:0] FULL_ON_WINDOW_RST = 16'd1000;
  localparam logic [15:0] FIRE_CUTOFF_RST    = 16'd8000;

  typedef enum logic [1:0] {
    CMD_UPDATE     = 2'd0,
    CMD_ZERO_CROSS = 2'd1,
    CMD_SET_POWER  = 2'd2,
    CMD_STOP       = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    CFG_MAX_POWER      = 2'd0,
    CFG_HALF_PERIOD    = 2'd1,
    CFG_FULL_ON_WINDOW = 2'd2,
    CFG_FIRE_CUTOFF    = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [1:0]  command;
    logic [1:0]  channel;
    logic [7:0]  power;
    logic [31:0] now_us;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  gates;
    logic [2:0]  active_mask;
    logic [31:0] since_zero_us;
  } result_t;

  typedef struct packed {
    logic        update;
    logic        clear_fired;
    logic [31:0] elapsed;
    logic [15:0] half_period;
    logic [15:0] full_on_window;
    logic [15:0] fire_cutoff;
  } chan_ctl_t;

endpackage

`default_nettype wire

@@ design/tpaf_chan.sv @@
// Firing decision for one gate channel against the elapsed time.
`timescale 1ns / 1ps
`default_nettype none

module tpaf_chan (
  input  tpaf_pkg::chan_ctl_t ctl_i,
  input  logic [6:0]          power_i,
  input  logic                fired_i,
  input  logic                gate_i,
  output logic                fired_o,
  output logic                gate_o
);
  import tpaf_pkg::*;

  logic [6:0]  rest;
  logic [22:0] delay_prod;
  logic [22:0] elapsed_scaled;
  logic        reached;
  logic        fire_ok;
  logic        fired_base;
  logic        high;
  logic        fired_next;

  // The delay point is reached when floor(hp * (100 - p) / 100) <= elapsed,
  // which is hp * (100 - p) <= 100 * elapsed + 99.
  assign rest           = FULL_POWER - power_i;
  assign delay_prod     = 23'(ctl_i.half_period) * 23'(rest);
  assign elapsed_scaled = 23'(ctl_i.elapsed[15:0]) * 23'(FULL_POWER)
                          + 23'(FULL_POWER - 7'd1);
  assign reached        = (ctl_i.elapsed[31:16] != 16'd0) || (elapsed_scaled >= delay_prod);
  assign fire_ok        = reached && (ctl_i.elapsed < {16'd0, ctl_i.fire_cutoff});
  assign fired_base     = ctl_i.clear_fired ? 1'b0 : fired_i;

  always_comb begin
    high       = 1'b0;
    fired_next = fired_base;
    if (power_i == 7'd0) begin
      fired_next = 1'b0;
    end else if (power_i >= FULL_POWER) begin
      if (ctl_i.elapsed < {16'd0, ctl_i.full_on_window}) begin
        high       = 1'b1;
        fired_next = 1'b1;
      end
    end else if (!fired_base && fire_ok) begin
      high       = 1'b1;
      fired_next = 1'b1;
    end
  end

  assign fired_o = ctl_i.update ? fired_next : fired_i;
  assign gate_o  = ctl_i.update ? high : gate_i;

endmodule

`default_nettype wire

@@ design/tpaf_obuf.sv @@
// Two-entry result buffer between the processing stage and the output port.
`timescale 1ns / 1ps
`default_nettype none

module tpaf_obuf (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  tpaf_pkg::result_t data_i,
  output logic              full_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output tpaf_pkg::result_t data_o
);
  import tpaf_pkg::*;

  result_t    slot_q [2];
  logic       wr_ptr_q;
  logic       wr_ptr_d;
  logic       rd_ptr_q;
  logic       rd_ptr_d;
  logic [1:0] cnt_q;
  logic [1:0] cnt_d;
  logic       pop;

  assign out_valid_o = (cnt_q != 2'd0);
  assign full_o      = (cnt_q == 2'd2);
  assign pop         = out_valid_o && out_ready_i;
  assign data_o      = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, push_i} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

@@ design/triac_phase_angle_firing_top.sv @@
// Top level of the three-channel triac phase-angle firing controller.
// An accepted word waits in the input register until its result is pushed into the
// two-entry result buffer, which absorbs output stalls and offers it at the output.
// Throughput is one word per cycle while the result buffer is not full.
// Reset clears powers, fired flags, gate levels and the zero-cross record, and loads
// the register defaults.
`timescale 1ns / 1ps
`default_nettype none

module triac_phase_angle_firing_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  command_i,
  input  logic [1:0]  channel_i,
  input  logic [7:0]  power_i,
  input  logic [31:0] now_us_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        gate_first_o,
  output logic        gate_second_o,
  output logic        gate_third_o,
  output logic [2:0]  active_mask_o,
  output logic [31:0] since_zero_us_o
);
  import tpaf_pkg::*;

  logic [6:0]  max_power_q;
  logic [15:0] half_period_q;
  logic [15:0] full_on_window_q;
  logic [15:0] fire_cutoff_q;

  in_item_t    s1_q;
  logic        s1_valid_q;
  logic        s1_valid_d;
  logic        in_accept;
  logic        advance;
  logic        obuf_full;

  logic [6:0]  power_q [NUM_CHANNELS];
  logic [6:0]  power_d [NUM_CHANNELS];
  logic [6:0]  power_eff [NUM_CHANNELS];
  logic [2:0]  fired_q;
  logic [2:0]  fired_d;
  logic [2:0]  gate_q;
  logic [2:0]  gate_d;
  logic [31:0] stamp_q;
  logic [31:0] stamp_d;
  logic        seen_q;
  logic        seen_d;

  cmd_e        cmd;
  logic        chan_ok;
  logic [6:0]  lim;
  logic [6:0]  power_new;
  chan_ctl_t   ctl;
  logic [2:0]  chan_fired;
  logic [2:0]  chan_gate;
  result_t     res;
  result_t     out_res;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_power_q      <= MAX_POWER_RST;
      half_period_q    <= HALF_PERIOD_RST;
      full_on_window_q <= FULL_ON_WINDOW_RST;
      fire_cutoff_q    <= FIRE_CUTOFF_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_MAX_POWER:      max_power_q      <= cfg_wdata_i[6:0];
        CFG_HALF_PERIOD:    half_period_q    <= cfg_wdata_i;
        CFG_FULL_ON_WINDOW: full_on_window_q <= cfg_wdata_i;
        CFG_FIRE_CUTOFF:    fire_cutoff_q    <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Input register.
  assign advance    = s1_valid_q && !obuf_full;
  assign in_ready_o = !s1_valid_q || !obuf_full;
  assign in_accept  = in_valid_i && in_ready_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_accept) begin
      s1_valid_d = 1'b1;
    end else if (advance) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_q <= '{command: command_i, channel: channel_i, power: power_i, now_us: now_us_i};
    end
  end

  // Processing stage.
  assign cmd       = cmd_e'(s1_q.command);
  assign chan_ok   = (s1_q.channel < 2'(NUM_CHANNELS));
  assign lim       = (max_power_q > FULL_POWER) ? FULL_POWER : max_power_q;
  assign power_new = (s1_q.power > {1'b0, lim}) ? lim : s1_q.power[6:0];

  always_comb begin
    for (int i = 0; i < NUM_CHANNELS; i++) begin
      power_eff[i] = (cmd == CMD_SET_POWER && s1_q.channel == 2'(i)) ? power_new : power_q[i];
    end
  end

  assign ctl.update         = seen_q && ((cmd == CMD_UPDATE) ||
                                         (cmd == CMD_SET_POWER && chan_ok));
  assign ctl.elapsed        = s1_q.now_us - stamp_q;
  assign ctl.clear_fired    = (ctl.elapsed > {16'd0, half_period_q});
  assign ctl.half_period    = half_period_q;
  assign ctl.full_on_window = full_on_window_q;
  assign ctl.fire_cutoff    = fire_cutoff_q;

  for (genvar g = 0; g < NUM_CHANNELS; g++) begin : g_chan
    tpaf_chan u_chan (
      .ctl_i   (ctl),
      .power_i (power_eff[g]),
      .fired_i (fired_q[g]),
      .gate_i  (gate_q[g]),
      .fired_o (chan_fired[g]),
      .gate_o  (chan_gate[g])
    );
  end

  always_comb begin
    power_d = power_q;
    fired_d = fired_q;
    gate_d  = gate_q;
    stamp_d = stamp_q;
    seen_d  = seen_q;
    case (cmd)
      CMD_UPDATE, CMD_SET_POWER: begin
        power_d = power_eff;
        fired_d = chan_fired;
        gate_d  = chan_gate;
      end
      CMD_ZERO_CROSS: begin
        stamp_d = s1_q.now_us;
        seen_d  = 1'b1;
        fired_d = '0;
      end
      CMD_STOP: begin
        for (int i = 0; i < NUM_CHANNELS; i++) begin
          power_d[i] = 7'd0;
        end
        gate_d = '0;
      end
      default: ;
    endcase
  end

  always_comb begin
    res.gates = gate_d;
    for (int i = 0; i < NUM_CHANNELS; i++) begin
      res.active_mask[i] = (power_d[i] != 7'd0);
    end
    res.since_zero_us = seen_d ? (s1_q.now_us - stamp_d) : 32'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        power_q[i] <= 7'd0;
      end
      fired_q <= '0;
      gate_q  <= '0;
      stamp_q <= '0;
      seen_q  <= 1'b0;
    end else if (advance) begin
      power_q <= power_d;
      fired_q <= fired_d;
      gate_q  <= gate_d;
      stamp_q <= stamp_d;
      seen_q  <= seen_d;
    end
  end

  // Result buffer.
  tpaf_obuf u_obuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (advance),
    .data_i      (res),
    .full_o      (obuf_full),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .data_o      (out_res)
  );

  assign gate_first_o    = out_res.gates[0];
  assign gate_second_o   = out_res.gates[1];
  assign gate_third_o    = out_res.gates[2];
  assign active_mask_o   = out_res.active_mask;
  assign since_zero_us_o = out_res.since_zero_us;

endmodule

`default_nettype wire

@@ tb/triac_phase_angle_firing_top_tb.sv @@
// Self-checking testbench for the three-channel triac phase-angle firing controller.
`timescale 1ns / 1ps

module triac_phase_angle_firing_top_tb;
  import tpaf_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1000000;

  logic        clk_i;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = CFG_MAX_POWER;
  logic [15:0] cfg_wdata_i = 16'd0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  command_i = CMD_UPDATE;
  logic [1:0]  channel_i = 2'd0;
  logic [7:0]  power_i = 8'd0;
  logic [31:0] now_us_i = 32'd0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic        gate_first_o;
  logic        gate_second_o;
  logic        gate_third_o;
  logic [2:0]  active_mask_o;
  logic [31:0] since_zero_us_o;

  triac_phase_angle_firing_top dut (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_wdata_i,
    .in_valid_i,
    .in_ready_o,
    .command_i,
    .channel_i,
    .power_i,
    .now_us_i,
    .out_valid_o,
    .out_ready_i,
    .gate_first_o,
    .gate_second_o,
    .gate_third_o,
    .active_mask_o,
    .since_zero_us_o
  );

  // Predicted controller state and register copies.
  logic [6:0]  max_power_m;
  logic [15:0] half_period_m;
  logic [15:0] full_on_m;
  logic [15:0] fire_cutoff_m;
  logic [6:0]  power_m [3];
  logic [2:0]  fired_m;
  logic [2:0]  gates_m;
  logic [31:0] zero_stamp_m;
  logic        zero_seen_m;

  result_t gate_report_q [$];
  result_t want;

  int unsigned errors = 0;
  int unsigned words_sent = 0;
  int unsigned results_checked = 0;
  int unsigned settings_used = 1;
  int unsigned cycle_count = 0;
  int unsigned ready_hold = 0;
  bit          stall_mode = 1'b1;
  bit          gaps_on = 1'b1;

  logic [31:0] clock_us;
  logic [31:0] last_zc_us;
  logic [31:0] zc_span;

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic void reset_model();
    int i;
    max_power_m   = MAX_POWER_RST;
    half_period_m = HALF_PERIOD_RST;
    full_on_m     = FULL_ON_WINDOW_RST;
    fire_cutoff_m = FIRE_CUTOFF_RST;
    for (i = 0; i < 3; i++) power_m[i] = 7'd0;
    fired_m      = 3'b000;
    gates_m      = 3'b000;
    zero_stamp_m = 32'd0;
    zero_seen_m  = 1'b0;
  endfunction

  function automatic void tick_gates(input logic [31:0] now);
    logic [31:0] elapsed;
    logic [31:0] delay;
    logic        high;
    int          i;
    if (!zero_seen_m) return;
    elapsed = now - zero_stamp_m;
    if (elapsed > {16'd0, half_period_m}) fired_m = 3'b000;
    for (i = 0; i < 3; i++) begin
      high = 1'b0;
      if (power_m[i] == 7'd0) begin
        fired_m[i] = 1'b0;
      end else if (power_m[i] >= FULL_POWER) begin
        if (elapsed < {16'd0, full_on_m}) begin
          high = 1'b1;
          fired_m[i] = 1'b1;
        end
      end else if (!fired_m[i]) begin
        delay = ({16'd0, half_period_m} * {25'd0, FULL_POWER - power_m[i]}) / 32'd100;
        if (elapsed >= delay && elapsed < {16'd0, fire_cutoff_m}) begin
          high = 1'b1;
          fired_m[i] = 1'b1;
        end
      end
      gates_m[i] = high;
    end
  endfunction

  function automatic result_t predict_gate_report(input in_item_t w);
    result_t    r;
    logic [6:0] limit;
    int         i;
    case (w.command)
      CMD_UPDATE: tick_gates(w.now_us);
      CMD_ZERO_CROSS: begin
        zero_stamp_m = w.now_us;
        zero_seen_m  = 1'b1;
        fired_m      = 3'b000;
      end
      CMD_SET_POWER: begin
        if (w.channel < 2'd3) begin
          limit = (max_power_m > FULL_POWER) ? FULL_POWER : max_power_m;
          power_m[w.channel] = ({1'b0, limit} < w.power) ? limit : w.power[6:0];
          tick_gates(w.now_us);
        end
      end
      default: begin
        for (i = 0; i < 3; i++) power_m[i] = 7'd0;
        gates_m = 3'b000;
      end
    endcase
    r.gates = gates_m;
    for (i = 0; i < 3; i++) r.active_mask[i] = (power_m[i] != 7'd0);
    r.since_zero_us = zero_seen_m ? (w.now_us - zero_stamp_m) : 32'd0;
    return r;
  endfunction

  function automatic in_item_t make_word(input cmd_e cmd, input logic [1:0] ch,
                                         input logic [7:0] pwr, input logic [31:0] t);
    in_item_t w;
    w.command = cmd;
    w.channel = ch;
    w.power   = pwr;
    w.now_us  = t;
    return w;
  endfunction

  task automatic send_word(input in_item_t w);
    int unsigned gap;
    int unsigned r;
    gap = 0;
    r = $urandom_range(0, 99);
    if (gaps_on && r >= 60) gap = (r < 93) ? $urandom_range(1, 3) : $urandom_range(4, 30);
    @(negedge clk_i);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    command_i  <= w.command;
    channel_i  <= w.channel;
    power_i    <= w.power;
    now_us_i   <= w.now_us;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    gate_report_q.push_back(predict_gate_report(w));
    words_sent++;
  endtask

  // Lowers valid and waits until every outstanding result has been taken.
  task automatic settle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (gate_report_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [15:0] value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    case (idx)
      CFG_MAX_POWER:      max_power_m   = value[6:0];
      CFG_HALF_PERIOD:    half_period_m = value;
      CFG_FULL_ON_WINDOW: full_on_m     = value;
      default:            fire_cutoff_m = value;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic write_all(input logic [15:0] max_pwr, input logic [15:0] half,
                           input logic [15:0] window, input logic [15:0] cutoff);
    settle();
    write_reg(CFG_MAX_POWER, max_pwr);
    write_reg(CFG_HALF_PERIOD, half);
    write_reg(CFG_FULL_ON_WINDOW, window);
    write_reg(CFG_FIRE_CUTOFF, cutoff);
    settings_used++;
  endtask

  // Mostly regular mains half periods with ticks and power changes in between,
  // plus missed zero crossings, stops and entirely random words.
  task automatic run_mains(input int unsigned words);
    int unsigned k;
    int unsigned r;
    int unsigned step_max;
    logic [7:0]  pwr;
    logic [1:0]  ch;
    in_item_t    w;
    clock_us   = $urandom();
    last_zc_us = clock_us;
    zc_span    = 32'd0;
    for (k = 0; k < words; k++) begin
      if ($urandom_range(0, 63) == 0) gaps_on = !gaps_on;
      step_max = half_period_m / 10 + 2;
      r = $urandom_range(0, 99);
      case ($urandom_range(0, 9))
        0:       pwr = 8'd0;
        1:       pwr = 8'd100;
        2:       pwr = 8'($urandom_range(101, 255));
        default: pwr = 8'($urandom_range(1, 99));
      endcase
      ch = ($urandom_range(0, 15) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
      if (r < 5) begin
        w = make_word(cmd_e'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                      8'($urandom_range(0, 255)), $urandom());
      end else if (clock_us - last_zc_us >= zc_span) begin
        w = make_word(CMD_ZERO_CROSS, 2'($urandom_range(0, 3)),
                      8'($urandom_range(0, 255)), clock_us);
        last_zc_us = clock_us;
        zc_span = half_period_m + $urandom_range(0, half_period_m / 8 + 4);
        if ($urandom_range(0, 11) == 0) zc_span = zc_span * 3;
      end else if (r < 8) begin
        w = make_word(CMD_STOP, 2'($urandom_range(0, 3)),
                      8'($urandom_range(0, 255)), clock_us);
      end else if (r < 24) begin
        clock_us = clock_us + $urandom_range(0, step_max / 2);
        w = make_word(CMD_SET_POWER, ch, pwr, clock_us);
      end else begin
        clock_us = clock_us + $urandom_range(0, step_max);
        w = make_word(CMD_UPDATE, 2'($urandom_range(0, 3)),
                      8'($urandom_range(0, 255)), clock_us);
      end
      send_word(w);
    end
  endtask

  task automatic test_directed();
    logic [31:0] zc;
    send_word(make_word(CMD_UPDATE, 2'd0, 8'd0, 32'd0));
    send_word(make_word(CMD_SET_POWER, 2'd0, 8'd100, 32'd5));
    send_word(make_word(CMD_SET_POWER, 2'd1, 8'd50, 32'd10));
    send_word(make_word(CMD_SET_POWER, 2'd2, 8'd255, 32'd15));
    send_word(make_word(CMD_SET_POWER, 2'd3, 8'd77, 32'd20));
    zc = 32'hFFFF_FFF0;
    send_word(make_word(CMD_ZERO_CROSS, 2'd0, 8'd0, zc));
    send_word(make_word(CMD_UPDATE, 2'd0, 8'd0, zc + 32'd100));
    send_word(make_word(CMD_UPDATE, 2'd0, 8'd0, zc + 32'd999));
    send_word(make_word(CMD_UPDATE, 2'd0, 8'd0, zc + 32'd1000));
    send_word(make_word(CMD_UPDATE, 2'd0, 8'd0, zc + 32'd5000));
    send_word(make_word(CMD_UPDATE, 2'd0, 8'd0, zc + 32'd5001));
    send_word(make_word(CMD_SET_POWER, 2'd2, 8'd0, zc + 32'd6000));
    send_word(make_word(CMD_UPDATE, 2'd0, 8'd0, zc + 32'd10001));
    zc = 32'hFFFF_FFFF;
    send_word(make_word(CMD_ZERO_CROSS, 2'd3, 8'hFF, zc));
    send_word(make_word(CMD_UPDATE, 2'd0, 8'd0, zc + 32'd4999));
    send_word(make_word(CMD_UPDATE, 2'd0, 8'd0, zc + 32'd5000));
    send_word(make_word(CMD_UPDATE, 2'd0, 8'd0, zc + 32'd7999));
    send_word(make_word(CMD_STOP, 2'd0, 8'd0, zc + 32'd8000));
    send_word(make_word(CMD_UPDATE, 2'd3, 8'hFF, 32'hFFFF_FFFF));
  endtask

  task automatic test_reset_settings();
    run_mains(400);
  endtask

  // Clamp above hundred: max_power written as all ones holds 127 and is limited to 100.
  task automatic test_upper_extremes();
    write_all(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    run_mains(300);
  endtask

  task automatic test_lower_extremes();
    write_all(16'h0000, 16'd1, 16'd0, 16'd0);
    run_mains(150);
    write_all(16'd100, 16'd1, 16'd1, 16'd1);
    run_mains(150);
  endtask

  task automatic test_zero_half_period();
    write_all(16'd60, 16'd0, 16'd2, 16'd5);
    run_mains(200);
  endtask

  task automatic test_random_settings();
    int n;
    for (n = 0; n < 4; n++) begin
      write_all(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
      run_mains(200);
    end
  endtask

  always @(negedge clk_i) begin
    if (ready_hold != 0) begin
      ready_hold = ready_hold - 1;
    end else begin
      if ($urandom_range(0, 15) == 0) stall_mode = !stall_mode;
      if (stall_mode && $urandom_range(0, 1) == 0) begin
        out_ready_i <= 1'b0;
        ready_hold = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 2);
      end else begin
        out_ready_i <= 1'b1;
        ready_hold = stall_mode ? $urandom_range(0, 4) : $urandom_range(20, 150);
      end
    end
  end

  task automatic show_mismatch(input string what, input logic [31:0] exp_val,
                               input logic [31:0] got_val);
    $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, what, exp_val, got_val);
    errors++;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (gate_report_q.size() == 0) begin
        $display("%0t ns: result word with nothing expected, gates %b mask %b since %0h",
                 $time, {gate_third_o, gate_second_o, gate_first_o}, active_mask_o,
                 since_zero_us_o);
        errors++;
      end else begin
        want = gate_report_q.pop_front();
        results_checked++;
        if (want.gates != {gate_third_o, gate_second_o, gate_first_o})
          show_mismatch("gates", 32'(want.gates),
                        32'({gate_third_o, gate_second_o, gate_first_o}));
        if (want.active_mask != active_mask_o)
          show_mismatch("active_mask", 32'(want.active_mask), 32'(active_mask_o));
        if (want.since_zero_us != since_zero_us_o)
          show_mismatch("since_zero_us", want.since_zero_us, since_zero_us_o);
      end
    end
  end

  initial begin
    reset_model();
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_reset_settings();
    test_upper_extremes();
    test_lower_extremes();
    test_zero_half_period();
    test_random_settings();
    settle();
    $display("Sent %0d words under %0d register settings, including wrap-round timestamps,",
             words_sent, settings_used);
    $display("clamped powers and a zero half period; %0d results compared, %0d mismatches.",
             results_checked, errors);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
